[rtl/pfde_pkg.sv]
// shared types and constants of the page-mode frame store draw engine
// no dependencies

package pfde_pkg;

  localparam int DEF_MAX_WIDTH = 128;
  localparam int DEF_MAX_PAGES = 8;

  localparam logic [2:0] OP_FILL    = 3'd0;
  localparam logic [2:0] OP_PIXEL   = 3'd1;
  localparam logic [2:0] OP_RECT    = 3'd2;
  localparam logic [2:0] OP_HSCROLL = 3'd3;
  localparam logic [2:0] OP_VSCROLL = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;

  localparam logic [1:0] REG_PANEL_WIDTH  = 2'd0;
  localparam logic [1:0] REG_PANEL_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    K_SKIP,
    K_RMW,
    K_HCOPY,
    K_VSCROLL,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        no_effect;
    logic        color;
    logic        dir;
    logic [5:0]  shift;
    logic [8:0]  col0;
    logic [8:0]  ncol;
    logic [2:0]  pg_lo;
    logic [2:0]  pg_hi;
    logic [6:0]  row_lo;
    logic [6:0]  row_hi;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       no_effect;
  } res_t;

endpackage

[rtl/pfde_front.sv]
// front end: panel registers, command decode and clipping, command queue
// depends on pfde_pkg

module pfde_front #(
  parameter int MAX_WIDTH = pfde_pkg::DEF_MAX_WIDTH,
  parameter int MAX_PAGES = pfde_pkg::DEF_MAX_PAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              push,
  input  logic [2:0]        operation,
  input  logic [7:0]        x_pos,
  input  logic [6:0]        y_pos,
  input  logic [7:0]        rect_width,
  input  logic [6:0]        rect_height,
  input  logic              color,
  input  logic              direction,
  input  logic [5:0]        shift_amount,
  input  logic [2:0]        page_index,
  output logic              full,
  output logic              q_valid,
  output pfde_pkg::cmd_t    q_head,
  input  logic              q_pop
);

  logic [7:0] pw_r;
  logic [6:0] ph_r;
  pfde_pkg::cmd_t q_r [2];
  pfde_pkg::cmd_t cmd;
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  logic [8:0] w_eff;
  logic [3:0] p_eff;
  logic [6:0] h_eff;
  logic signed [10:0] xs, xa, xb0, xb, xlim;
  logic signed [8:0]  ys, ya, yb0, yb, ylim;
  logic       xok, yok, full_reg, hok, vok, none_h, none_v, pix_in, rd_in;
  logic [8:0] xlo, xn, hx0, hnx;
  logic [6:0] ylo, yn, yhi, yhi_m1, vlo, vhi, vny;

  always_comb begin
    w_eff = ({1'b0, pw_r} > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : {1'b0, pw_r};
    p_eff = (ph_r[6:3] > 4'(MAX_PAGES)) ? 4'(MAX_PAGES) : ph_r[6:3];
    h_eff = {p_eff, 3'b000};

    xs   = {{3{x_pos[7]}}, x_pos};
    xa   = xs[10] ? 11'sd0 : xs;
    xb0  = xs + $signed({3'b000, rect_width});
    xlim = $signed({2'b00, w_eff});
    xb   = (xb0 > xlim) ? xlim : xb0;
    xok  = xb > xa;
    xlo  = xa[8:0];
    xn   = 9'(xb - xa);

    ys   = {{2{y_pos[6]}}, y_pos};
    ya   = ys[8] ? 9'sd0 : ys;
    yb0  = ys + $signed({2'b00, rect_height});
    ylim = $signed({2'b00, h_eff});
    yb   = (yb0 > ylim) ? ylim : yb0;
    yok  = yb > ya;
    ylo  = ya[6:0];
    yn   = 7'(yb - ya);
    yhi  = ylo + yn;
    yhi_m1 = yhi - 7'd1;

    full_reg = (rect_width == 8'd0);
    hok    = full_reg || xok;
    hx0    = full_reg ? 9'd0 : xlo;
    hnx    = full_reg ? w_eff : xn;
    none_h = !hok || (hnx <= {3'b000, shift_amount});
    vok    = full_reg || (xok && yok);
    vlo    = full_reg ? 7'd0 : ylo;
    vhi    = full_reg ? h_eff : yhi;
    vny    = full_reg ? h_eff : yn;
    none_v = !vok || (hnx == 9'd0) || (vny <= {1'b0, shift_amount});

    pix_in = !xs[10] && (xs < xlim) && !ys[8] && (ys < ylim);
    rd_in  = !xs[10] && (xs < xlim) && ({1'b0, page_index} < p_eff);

    cmd = '0;
    cmd.kind      = pfde_pkg::K_SKIP;
    cmd.no_effect = 1'b1;
    cmd.color     = color;
    cmd.dir       = direction;
    cmd.shift     = shift_amount;
    case (operation)
      pfde_pkg::OP_FILL: begin
        if (w_eff != 9'd0 && p_eff != 4'd0) begin
          cmd.kind      = pfde_pkg::K_RMW;
          cmd.no_effect = 1'b0;
          cmd.ncol      = w_eff;
          cmd.row_hi    = h_eff;
          cmd.pg_hi     = 3'(p_eff - 4'd1);
        end
      end
      pfde_pkg::OP_PIXEL: begin
        if (pix_in) begin
          cmd.kind      = pfde_pkg::K_RMW;
          cmd.no_effect = 1'b0;
          cmd.col0      = {1'b0, x_pos};
          cmd.ncol      = 9'd1;
          cmd.row_lo    = y_pos;
          cmd.row_hi    = y_pos + 7'd1;
          cmd.pg_lo     = y_pos[5:3];
          cmd.pg_hi     = y_pos[5:3];
        end
      end
      pfde_pkg::OP_RECT: begin
        if (xok && yok) begin
          cmd.kind      = pfde_pkg::K_RMW;
          cmd.no_effect = 1'b0;
          cmd.col0      = xlo;
          cmd.ncol      = xn;
          cmd.row_lo    = ylo;
          cmd.row_hi    = yhi;
          cmd.pg_lo     = ylo[5:3];
          cmd.pg_hi     = yhi_m1[5:3];
        end
      end
      pfde_pkg::OP_HSCROLL: begin
        if (!none_h) begin
          cmd.no_effect = 1'b0;
          if (p_eff != 4'd0) begin
            cmd.kind  = pfde_pkg::K_HCOPY;
            cmd.col0  = direction ? (hx0 + hnx - 9'd1) : hx0;
            cmd.ncol  = hnx - {3'b000, shift_amount};
            cmd.pg_hi = 3'(p_eff - 4'd1);
          end
        end
      end
      pfde_pkg::OP_VSCROLL: begin
        if (!none_v) begin
          cmd.kind      = pfde_pkg::K_VSCROLL;
          cmd.no_effect = 1'b0;
          cmd.col0      = hx0;
          cmd.ncol      = hnx;
          cmd.row_lo    = vlo;
          cmd.row_hi    = vhi;
          cmd.pg_hi     = 3'(p_eff - 4'd1);
        end
      end
      pfde_pkg::OP_READ: begin
        if (rd_in) begin
          cmd.kind      = pfde_pkg::K_READ;
          cmd.no_effect = 1'b0;
          cmd.col0      = {1'b0, x_pos};
          cmd.pg_lo     = page_index;
        end
      end
      default: begin
      end
    endcase
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r   <= 8'd128;
      ph_r   <= 7'd64;
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pfde_pkg::REG_PANEL_WIDTH:  pw_r <= cfg_data;
          pfde_pkg::REG_PANEL_HEIGHT: ph_r <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      if (push) begin
        q_r[wptr_r] <= cmd;
        wptr_r      <= ~wptr_r;
      end
      if (q_pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[rtl/pfde_back.sv]
// back end: frame store memory, clearing pass, command sequencer, result queue
// depends on pfde_pkg

module pfde_back #(
  parameter int MAX_WIDTH = pfde_pkg::DEF_MAX_WIDTH,
  parameter int MAX_PAGES = pfde_pkg::DEF_MAX_PAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  pfde_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              clearing,
  output logic              out_empty,
  input  logic              out_pop,
  output pfde_pkg::res_t    out_res
);

  localparam int DEPTH = MAX_PAGES * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int WORD  = 8 * MAX_PAGES;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RUN, S_VRD, S_VLAST, S_VCALC, S_VWR, S_RD, S_RD2
  } state_t;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;
  logic       we;
  logic [AW-1:0] wa, ra;
  logic [7:0] wd;

  state_t         state_r, state_nxt;
  pfde_pkg::cmd_t cmd_r, cmd_nxt;
  logic [8:0]     col_r, col_nxt, ncol_r, ncol_nxt, src_col;
  logic [2:0]     pg_r, pg_nxt, vcap_pg_r, vcap_pg_nxt;
  logic           issue_r, issue_nxt, pend_r, pend_nxt, vcap_r, vcap_nxt;
  logic [AW-1:0]  pend_addr_r, pend_addr_nxt, clr_r, clr_nxt;
  logic [7:0]     pend_mask_r, pend_mask_nxt;
  logic [WORD-1:0] word_r, word_nxt, vmask_r, vmask_nxt;
  logic           push;
  pfde_pkg::res_t push_res;
  pfde_pkg::res_t oq_r [2];
  logic           owptr_r, orptr_r;
  logic [1:0]     ocnt_r;

  function automatic logic [AW-1:0] addr_f(input logic [2:0] pg, input logic [8:0] col);
    addr_f = AW'(int'(pg) * MAX_WIDTH + int'(col));
  endfunction

  function automatic logic [7:0] pmask_f(input logic [2:0] pg, input logic [6:0] lo,
                                         input logic [6:0] hi);
    logic [6:0] r;
    pmask_f = '0;
    for (int i = 0; i < 8; i++) begin
      r = {1'b0, pg, 3'(i)};
      pmask_f[i] = (r >= lo) && (r < hi);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  assign clearing  = (state_r == S_CLEAR);
  assign out_empty = (ocnt_r == 2'd0);
  assign out_res   = oq_r[orptr_r];
  assign src_col   = (cmd_r.kind != pfde_pkg::K_HCOPY) ? col_r :
                     cmd_r.dir ? (col_r - {3'b000, cmd_r.shift}) :
                                 (col_r + {3'b000, cmd_r.shift});

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    col_nxt       = col_r;
    ncol_nxt      = ncol_r;
    pg_nxt        = pg_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    pend_mask_nxt = pend_mask_r;
    vcap_nxt      = 1'b0;
    vcap_pg_nxt   = vcap_pg_r;
    word_nxt      = word_r;
    vmask_nxt     = vmask_r;
    clr_nxt       = clr_r;
    q_pop         = 1'b0;
    push          = 1'b0;
    push_res.read_data = 8'h00;
    push_res.no_effect = cmd_r.no_effect;
    we = 1'b0;
    wa = pend_addr_r;
    wd = 8'h00;
    ra = addr_f(pg_r, src_col);

    if (pend_r) begin
      we = 1'b1;
      if (cmd_r.kind == pfde_pkg::K_HCOPY) begin
        wd = rdata_r;
      end else if (cmd_r.color) begin
        wd = rdata_r | pend_mask_r;
      end else begin
        wd = rdata_r & ~pend_mask_r;
      end
    end
    if (vcap_r) begin
      word_nxt[vcap_pg_r*8 +: 8] = rdata_r;
    end

    case (state_r)
      S_CLEAR: begin
        we      = 1'b1;
        wa      = clr_r;
        wd      = 8'h00;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && ocnt_r != 2'd2) begin
          q_pop    = 1'b1;
          cmd_nxt  = q_head;
          col_nxt  = q_head.col0;
          ncol_nxt = q_head.ncol;
          pg_nxt   = q_head.pg_lo;
          word_nxt = '0;
          for (int i = 0; i < WORD; i++) begin
            vmask_nxt[i] = (7'(i) >= q_head.row_lo) && (7'(i) < q_head.row_hi);
          end
          case (q_head.kind)
            pfde_pkg::K_RMW, pfde_pkg::K_HCOPY: begin
              issue_nxt = 1'b1;
              state_nxt = S_RUN;
            end
            pfde_pkg::K_VSCROLL: state_nxt = S_VRD;
            pfde_pkg::K_READ:    state_nxt = S_RD;
            default: begin
              push               = 1'b1;
              push_res.no_effect = q_head.no_effect;
            end
          endcase
        end
      end
      S_RUN: begin
        if (issue_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = addr_f(pg_r, col_r);
          pend_mask_nxt = pmask_f(pg_r, cmd_r.row_lo, cmd_r.row_hi);
          if (pg_r == cmd_r.pg_hi) begin
            pg_nxt   = cmd_r.pg_lo;
            ncol_nxt = ncol_r - 9'd1;
            col_nxt  = (cmd_r.kind == pfde_pkg::K_HCOPY && cmd_r.dir) ?
                       (col_r - 9'd1) : (col_r + 9'd1);
            if (ncol_r == 9'd1) begin
              issue_nxt = 1'b0;
            end
          end else begin
            pg_nxt = pg_r + 3'd1;
          end
        end else if (!pend_r) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_VRD: begin
        vcap_nxt    = 1'b1;
        vcap_pg_nxt = pg_r;
        if (pg_r == cmd_r.pg_hi) begin
          state_nxt = S_VLAST;
        end else begin
          pg_nxt = pg_r + 3'd1;
        end
      end
      S_VLAST: begin
        state_nxt = S_VCALC;
      end
      S_VCALC: begin
        if (cmd_r.dir) begin
          word_nxt = (word_r & ~vmask_r) | ((word_r << cmd_r.shift) & vmask_r);
        end else begin
          word_nxt = (word_r & ~vmask_r) | ((word_r >> cmd_r.shift) & vmask_r);
        end
        pg_nxt    = 3'd0;
        state_nxt = S_VWR;
      end
      S_VWR: begin
        we = 1'b1;
        wa = addr_f(pg_r, col_r);
        wd = word_r[pg_r*8 +: 8];
        if (pg_r == cmd_r.pg_hi) begin
          pg_nxt = 3'd0;
          if (ncol_r == 9'd1) begin
            push      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            col_nxt   = col_r + 9'd1;
            ncol_nxt  = ncol_r - 9'd1;
            state_nxt = S_VRD;
          end
        end else begin
          pg_nxt = pg_r + 3'd1;
        end
      end
      S_RD: begin
        state_nxt = S_RD2;
      end
      S_RD2: begin
        push               = 1'b1;
        push_res.read_data = rdata_r;
        state_nxt          = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
      vcap_r  <= 1'b0;
      owptr_r <= 1'b0;
      orptr_r <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
      vcap_r  <= vcap_nxt;
      if (push) begin
        oq_r[owptr_r] <= push_res;
        owptr_r       <= ~owptr_r;
      end
      if (out_pop && !out_empty) begin
        orptr_r <= ~orptr_r;
      end
      ocnt_r <= ocnt_r + 2'(push) - 2'(out_pop && !out_empty);
    end
    cmd_r       <= cmd_nxt;
    col_r       <= col_nxt;
    ncol_r      <= ncol_nxt;
    pg_r        <= pg_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_mask_r <= pend_mask_nxt;
    vcap_pg_r   <= vcap_pg_nxt;
    word_r      <= word_nxt;
    vmask_r     <= vmask_nxt;
  end

endmodule

[rtl/page_framebuffer_draw_engine_unit.sv]
// top level of the page-mode frame store draw engine
// depends on pfde_pkg, pfde_front and pfde_back
//
//   channel   handshake               payload
//   in_       push / full             operation, position, size, color, scroll, page
//   out_      empty / pop             read_data, no_effect
//   cfg_      valid / ready           register index, write data
//
// fill, rectangle and horizontal scroll read and write back each byte touched in turn;
// a vertical scroll reads a column's pages, shifts them and writes them back; pixel and
// read touch one byte. the frame store memory has one read and one write port and its
// registered read. after reset a clearing pass over all MAX_PAGES*MAX_WIDTH words runs
// while full stays high. the front queue holds two requests and the result queue two.

module page_framebuffer_draw_engine_unit #(
  parameter int MAX_WIDTH = pfde_pkg::DEF_MAX_WIDTH,
  parameter int MAX_PAGES = pfde_pkg::DEF_MAX_PAGES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_x_pos,
  input  logic [6:0] in_y_pos,
  input  logic [7:0] in_rect_width,
  input  logic [6:0] in_rect_height,
  input  logic       in_color,
  input  logic       in_direction,
  input  logic [5:0] in_shift_amount,
  input  logic [2:0] in_page_index,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_read_data,
  output logic       out_no_effect
);

  logic           q_full, q_valid, q_pop, clearing;
  pfde_pkg::cmd_t q_head;
  pfde_pkg::res_t res;

  assign cfg_ready     = 1'b1;
  assign in_full       = q_full || clearing;
  assign out_read_data = res.read_data;
  assign out_no_effect = res.no_effect;

  pfde_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_PAGES (MAX_PAGES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (in_push && !in_full),
    .operation    (in_operation),
    .x_pos        (in_x_pos),
    .y_pos        (in_y_pos),
    .rect_width   (in_rect_width),
    .rect_height  (in_rect_height),
    .color        (in_color),
    .direction    (in_direction),
    .shift_amount (in_shift_amount),
    .page_index   (in_page_index),
    .full         (q_full),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  pfde_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_PAGES (MAX_PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

endmodule

[dv/testbench.sv]
// self-checking testbench of the page-mode frame store draw engine
// depends on pfde_pkg and page_framebuffer_draw_engine_unit; keeps its own shadow store
// a directed table runs first, then random phases under several panel settings
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int STORE_W = 128;
  localparam int STORE_P = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [2:0] op;
    logic [7:0] x;
    logic [6:0] y;
    logic [7:0] w;
    logic [6:0] h;
    logic       color;
    logic       dir;
    logic [5:0] sh;
    logic [2:0] pg;
  } draw_req_t;

  typedef struct {
    logic [7:0] rd;
    logic       ne;
  } draw_res_t;

  typedef struct {
    draw_req_t req;
    bit        typed;
    draw_res_t res;
  } table_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [2:0] in_operation = '0;
  logic [7:0] in_x_pos = '0;
  logic [6:0] in_y_pos = '0;
  logic [7:0] in_rect_width = '0;
  logic [6:0] in_rect_height = '0;
  logic       in_color = 1'b0;
  logic       in_direction = 1'b0;
  logic [5:0] in_shift_amount = '0;
  logic [2:0] in_page_index = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_read_data;
  logic       out_no_effect;

  logic [7:0] shadow_store [STORE_W*STORE_P];
  logic [7:0] shadow_width = 8'd128;
  logic [6:0] shadow_height = 7'd64;
  draw_res_t  pending_res [$];
  table_row_t dir_table [$];
  bit         cur_typed = 1'b0;
  draw_res_t  cur_res;
  bit         hold_reader = 1'b0;
  bit         no_gap = 1'b0;
  int         errors = 0;
  int         idle_cycles = 0;

  page_framebuffer_draw_engine_unit i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit clip_span(int pos, int len, int lim, output int lo, output int n);
    int a;
    int b;
    a = pos < 0 ? 0 : pos;
    b = pos + len;
    if (b > lim) b = lim;
    lo = a;
    n = b - a;
    return b > a;
  endfunction

  function automatic draw_res_t draw_step(draw_req_t r);
    int wd, pgs, ht, x, y, x0, nx, y0, ny, src, dst;
    logic [7:0] m;
    logic [63:0] mask, word;
    draw_res_t o;
    wd = shadow_width < STORE_W ? shadow_width : STORE_W;
    pgs = (shadow_height >> 3) < STORE_P ? (shadow_height >> 3) : STORE_P;
    ht = pgs * 8;
    x = $signed(r.x);
    y = $signed(r.y);
    o.rd = 8'h00;
    o.ne = 1'b0;
    case (r.op)
      pfde_pkg::OP_FILL: begin
        if (wd == 0 || pgs == 0) o.ne = 1'b1;
        else
          for (int p = 0; p < pgs; p++)
            for (int c = 0; c < wd; c++) shadow_store[p*STORE_W+c] = {8{r.color}};
      end
      pfde_pkg::OP_PIXEL: begin
        if (x < 0 || x >= wd || y < 0 || y >= ht) o.ne = 1'b1;
        else shadow_store[(y>>3)*STORE_W+x][y&7] = r.color;
      end
      pfde_pkg::OP_RECT: begin
        if (!clip_span(x, r.w, wd, x0, nx) || !clip_span(y, r.h, ht, y0, ny)) o.ne = 1'b1;
        else
          for (int p = 0; p < pgs; p++) begin
            for (int i = 0; i < 8; i++) m[i] = (p*8+i >= y0) && (p*8+i < y0+ny);
            for (int c = x0; c < x0+nx; c++)
              if (r.color) shadow_store[p*STORE_W+c] |= m;
              else shadow_store[p*STORE_W+c] &= ~m;
          end
      end
      pfde_pkg::OP_HSCROLL: begin
        if (r.w == 0) begin
          x0 = 0;
          nx = wd;
        end else if (!clip_span(x, r.w, wd, x0, nx)) begin
          nx = 0;
        end
        if (nx <= r.sh) o.ne = 1'b1;
        else
          for (int i = 0; i < nx - r.sh; i++) begin
            dst = r.dir ? x0 + nx - 1 - i : x0 + i;
            src = r.dir ? dst - r.sh : dst + r.sh;
            for (int p = 0; p < pgs; p++)
              shadow_store[p*STORE_W+dst] = shadow_store[p*STORE_W+src];
          end
      end
      pfde_pkg::OP_VSCROLL: begin
        nx = 0;
        ny = 0;
        if (r.w == 0) begin
          x0 = 0;
          nx = wd;
          y0 = 0;
          ny = ht;
        end else if (!clip_span(x, r.w, wd, x0, nx) || !clip_span(y, r.h, ht, y0, ny)) begin
          nx = 0;
        end
        if (nx <= 0 || ny <= r.sh) o.ne = 1'b1;
        else begin
          mask = '0;
          for (int i = y0; i < y0 + ny && i < 64; i++) mask[i] = 1'b1;
          for (int c = x0; c < x0 + nx; c++) begin
            word = '0;
            for (int p = 0; p < pgs; p++) word[8*p +: 8] = shadow_store[p*STORE_W+c];
            if (r.dir) word = (word & ~mask) | ((word << r.sh) & mask);
            else word = (word & ~mask) | ((word >> r.sh) & mask);
            for (int p = 0; p < pgs; p++) shadow_store[p*STORE_W+c] = word[8*p +: 8];
          end
        end
      end
      pfde_pkg::OP_READ: begin
        if (x < 0 || x >= wd || r.pg >= pgs) o.ne = 1'b1;
        else o.rd = shadow_store[r.pg*STORE_W+x];
      end
      default: o.ne = 1'b1;
    endcase
    return o;
  endfunction

  function automatic draw_req_t mk(logic [2:0] op, int x, int y, int w, int h,
                                   bit color, bit dir, int sh, int pg);
    draw_req_t r;
    r.op = op;
    r.x = x[7:0];
    r.y = y[6:0];
    r.w = w[7:0];
    r.h = h[6:0];
    r.color = color;
    r.dir = dir;
    r.sh = sh[5:0];
    r.pg = pg[2:0];
    return r;
  endfunction

  function automatic void add_row(draw_req_t r, bit typed, logic [7:0] rd, logic ne);
    table_row_t t;
    t.req = r;
    t.typed = typed;
    t.res.rd = rd;
    t.res.ne = ne;
    dir_table.push_back(t);
  endfunction

  function automatic draw_req_t rand_req();
    int wd, ht, k;
    draw_req_t r;
    wd = shadow_width < STORE_W ? shadow_width : STORE_W;
    ht = ((shadow_height >> 3) < STORE_P ? (shadow_height >> 3) : STORE_P) * 8;
    r = mk(pfde_pkg::OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom);
    k = $urandom_range(0, 99);
    if (k < 30) r.op = pfde_pkg::OP_READ;
    else if (k < 52) r.op = pfde_pkg::OP_PIXEL;
    else if (k < 68) r.op = pfde_pkg::OP_RECT;
    else if (k < 79) r.op = pfde_pkg::OP_HSCROLL;
    else if (k < 90) r.op = pfde_pkg::OP_VSCROLL;
    else if (k < 95) r.op = pfde_pkg::OP_FILL;
    else r.op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
    if ($urandom_range(0, 3) != 0) begin
      r.x = 8'($urandom_range(0, wd > 0 ? wd - 1 : 0));
      r.y = 7'($urandom_range(0, ht > 0 ? ht - 1 : 0));
      r.pg = 3'($urandom_range(0, ht > 0 ? ht / 8 - 1 : 0));
      r.w = 8'($urandom_range(0, wd > 0 ? wd : 1));
      r.h = 7'($urandom_range(0, ht > 0 ? ht : 1));
      r.sh = 6'($urandom_range(0, 9));
    end
    return r;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [7:0] data);
    @(negedge clk);
    in_push = 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_req(draw_req_t r, bit typed, draw_res_t res);
    int gap, k;
    @(negedge clk);
    in_push = 1'b1;
    in_operation = r.op;
    in_x_pos = r.x;
    in_y_pos = r.y;
    in_rect_width = r.w;
    in_rect_height = r.h;
    in_color = r.color;
    in_direction = r.dir;
    in_shift_amount = r.sh;
    in_page_index = r.pg;
    cur_typed = typed;
    cur_res = res;
    @(posedge clk);
    while (in_full) @(posedge clk);
    k = $urandom_range(0, 99);
    gap = (no_gap || k < 45) ? 0 : (k < 90 ? $urandom_range(1, 3) : $urandom_range(10, 80));
    if (gap > 0) begin
      @(negedge clk);
      in_push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // request, configuration and result monitors
  always @(posedge clk) begin
    draw_res_t p;
    draw_res_t e;
    if (rst_n && in_push && !in_full) begin
      p = draw_step('{in_operation, in_x_pos, in_y_pos, in_rect_width, in_rect_height,
                      in_color, in_direction, in_shift_amount, in_page_index});
      pending_res.push_back(cur_typed ? cur_res : p);
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == pfde_pkg::REG_PANEL_WIDTH) shadow_width <= cfg_data;
      else if (cfg_index == pfde_pkg::REG_PANEL_HEIGHT) shadow_height <= cfg_data[6:0];
    end
    if (rst_n && out_pop && !out_empty) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result read_data=%0h no_effect=%0b", out_read_data, out_no_effect);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (out_read_data !== e.rd) begin
          $error("read_data expected %0h actual %0h", e.rd, out_read_data);
          errors++;
        end
        if (out_no_effect !== e.ne) begin
          $error("no_effect expected %0b actual %0b", e.ne, out_no_effect);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result reader with random stalls and one long hold-off
  initial begin
    int stall;
    int k;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_reader) begin
        out_pop = 1'b0;
        repeat (400) @(negedge clk);
        hold_reader = 1'b0;
      end else if (stall > 0) begin
        out_pop = 1'b0;
        stall--;
      end else begin
        out_pop = 1'b1;
        k = $urandom_range(0, 99);
        stall = k < 50 ? 0 : (k < 90 ? $urandom_range(1, 3) : $urandom_range(10, 80));
      end
    end
  end

  initial begin
    draw_res_t none_res;
    logic [7:0] widths [12] = '{8'd255, 8'd0, 8'd128, 8'd16, 8'd1, 8'd8, 8'd24, 8'd40,
                                8'd12, 8'd3, 8'd64, 8'd20};
    logic [7:0] heights [12] = '{8'd127, 8'd64, 8'd0, 8'd16, 8'd7, 8'd8, 8'd24, 8'd32,
                                 8'd16, 8'd8, 8'd64, 8'd15};
    none_res.rd = 8'h00;
    none_res.ne = 1'b0;
    for (int i = 0; i < STORE_W*STORE_P; i++) shadow_store[i] = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    add_row(mk(pfde_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_READ, 127, 0, 0, 0, 0, 0, 0, 7), 1, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_READ, -128, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00, 1'b1);
    add_row(mk(OP_SPARE6, 5, 5, 5, 5, 1, 1, 1, 1), 1, 8'h00, 1'b1);
    add_row(mk(OP_SPARE7, -1, -1, 255, 127, 1, 1, 63, 7), 1, 8'h00, 1'b1);
    add_row(mk(pfde_pkg::OP_PIXEL, 127, 63, 0, 0, 1, 0, 0, 0), 1, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_READ, 127, 0, 0, 0, 0, 0, 0, 7), 1, 8'h80, 1'b0);
    add_row(mk(pfde_pkg::OP_PIXEL, -1, 3, 0, 0, 1, 0, 0, 0), 1, 8'h00, 1'b1);
    add_row(mk(pfde_pkg::OP_PIXEL, 3, -64, 0, 0, 1, 0, 0, 0), 1, 8'h00, 1'b1);
    add_row(mk(pfde_pkg::OP_FILL, 0, 0, 0, 0, 1, 0, 0, 0), 1, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_READ, 5, 0, 0, 0, 0, 0, 0, 3), 1, 8'hff, 1'b0);
    add_row(mk(pfde_pkg::OP_RECT, -128, -64, 255, 127, 0, 0, 0, 0), 0, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_RECT, 4, 4, 0, 9, 1, 0, 0, 0), 1, 8'h00, 1'b1);
    add_row(mk(pfde_pkg::OP_RECT, 10, 3, 5, 20, 1, 0, 0, 0), 0, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_PIXEL, 12, 5, 0, 0, 0, 0, 0, 0), 0, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_HSCROLL, 0, 0, 0, 0, 0, 0, 63, 0), 0, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_HSCROLL, 0, 0, 0, 0, 0, 1, 1, 0), 0, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_HSCROLL, 120, 0, 8, 0, 0, 0, 63, 0), 1, 8'h00, 1'b1);
    add_row(mk(pfde_pkg::OP_VSCROLL, 0, 0, 0, 0, 0, 1, 5, 0), 0, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_VSCROLL, 0, 0, 0, 0, 0, 0, 63, 0), 0, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_VSCROLL, 5, 5, 3, 0, 0, 0, 0, 0), 1, 8'h00, 1'b1);
    add_row(mk(pfde_pkg::OP_VSCROLL, 8, 2, 4, 10, 0, 0, 3, 0), 0, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_READ, 10, 0, 0, 0, 0, 0, 0, 0), 0, 8'h00, 1'b0);
    add_row(mk(pfde_pkg::OP_READ, 127, 0, 0, 0, 0, 0, 0, 7), 0, 8'h00, 1'b0);
    foreach (dir_table[i]) send_req(dir_table[i].req, dir_table[i].typed, dir_table[i].res);

    for (int ph = 0; ph < 12; ph++) begin
      cfg_write(pfde_pkg::REG_PANEL_WIDTH, widths[ph]);
      cfg_write(pfde_pkg::REG_PANEL_HEIGHT, heights[ph]);
      if (ph == 3) begin
        hold_reader = 1'b1;
        no_gap = 1'b1;
        repeat (12) send_req(mk(pfde_pkg::OP_READ, $urandom_range(0, 15), 0, 0, 0, 0, 0, 0,
                                $urandom_range(0, 1)), 0, none_res);
        no_gap = 1'b0;
      end
      repeat (45) send_req(rand_req(), 0, none_res);
    end
    @(negedge clk);
    in_push = 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
